// ===== rtl/tbarx_pkg.sv =====
// Shared types, constants and helper functions for the two-block ARX stream cipher.
// Used by the interfaces, the controller, the datapath and the top level.
package tbarx_pkg;

  localparam int DOUBLE_ROUNDS_DEF = 6;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int CHUNK_W = 64;
  localparam int COUNT_W = 4;
  localparam int POS_W = 4;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KEY01 = 3'd0,
    REG_KEY23 = 3'd1,
    REG_KEY45 = 3'd2,
    REG_KEY67 = 3'd3,
    REG_LONG  = 3'd4,
    REG_NONCE = 3'd5
  } reg_index_t;

  // Row rotation applied at the end of a quarter step.
  typedef enum logic [1:0] {
    ROT_PLAIN,
    ROT_SKEW,
    ROT_UNSKEW
  } rot_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FEED,
    ST_EMIT
  } state_t;

  // One 16-word cipher state, word 0 in the low bits.
  typedef logic [15:0][31:0] words_t;

  typedef struct packed {
    logic      capture;
    logic      load;
    logic      round;
    logic [1:0] sub;
    rot_mode_t rot;
    logic      feed;
    logic      emit;
  } cmd_t;

  typedef struct packed {
    logic pos_zero;
    logic out_free;
  } status_t;

  localparam logic [31:0] LONG_CONSTS [4] = '{
    32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
  };
  localparam logic [31:0] SHORT_CONSTS [4] = '{
    32'h61707865, 32'h3120646e, 32'h79622d36, 32'h6b206574
  };

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  // Left rotation of one row for the given mode.
  function automatic logic [1:0] rot_amount(input rot_mode_t mode, input int row);
    logic [1:0] k;
    k = 2'd1;
    unique case (mode)
      ROT_SKEW:   k = 2'(1 + row);
      ROT_UNSKEW: k = 2'(1 - row);
      default:    k = 2'd1;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/tbarx_if.sv =====
// Stream channel interfaces for input chunks and cipher results.
// Depend on tbarx_pkg for the field widths.
interface tbarx_in_if;
  logic                             valid;
  logic                             ready;
  logic [tbarx_pkg::CHUNK_W-1:0]    message_chunk;
  logic [tbarx_pkg::COUNT_W-1:0]    byte_count;
  logic                             end_of_message;

  modport source (output valid, message_chunk, byte_count, end_of_message, input ready);
  modport sink (input valid, message_chunk, byte_count, end_of_message, output ready);
endinterface

interface tbarx_out_if;
  logic                             valid;
  logic                             ready;
  logic [tbarx_pkg::CHUNK_W-1:0]    cipher_chunk;
  logic                             chunk_is_last;

  modport source (output valid, cipher_chunk, chunk_is_last, input ready);
  modport sink (input valid, cipher_chunk, chunk_is_last, output ready);
endinterface

// ===== rtl/tbarx_ctrl.sv =====
// Controller state machine: sequences span build, rounds, feed-forward and result beats.
// Depends on tbarx_pkg for the state, command and status types.
module tbarx_ctrl #(
  parameter int DOUBLE_ROUNDS = tbarx_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tbarx_pkg::status_t sts,
  output tbarx_pkg::cmd_t    cmd
);

  localparam int DR_W = $clog2(DOUBLE_ROUNDS + 1);

  tbarx_pkg::state_t state, state_next;
  logic [1:0]      sub, sub_next;
  logic [2:0]      quarter, quarter_next;
  logic [DR_W-1:0] dround, dround_next;

  // State and step counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= tbarx_pkg::ST_IDLE;
      sub     <= '0;
      quarter <= '0;
      dround  <= '0;
    end else begin
      state   <= state_next;
      sub     <= sub_next;
      quarter <= quarter_next;
      dround  <= dround_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next   = state;
    sub_next     = sub;
    quarter_next = quarter;
    dround_next  = dround;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.sub      = sub;
    if (quarter == 3'd3) begin
      cmd.rot = tbarx_pkg::ROT_SKEW;
    end else if (quarter == 3'd7) begin
      cmd.rot = tbarx_pkg::ROT_UNSKEW;
    end else begin
      cmd.rot = tbarx_pkg::ROT_PLAIN;
    end
    unique case (state)
      tbarx_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = sts.pos_zero ? tbarx_pkg::ST_LOAD : tbarx_pkg::ST_EMIT;
        end
      end
      tbarx_pkg::ST_LOAD: begin
        cmd.load     = 1'b1;
        sub_next     = '0;
        quarter_next = '0;
        dround_next  = '0;
        state_next   = tbarx_pkg::ST_ROUND;
      end
      tbarx_pkg::ST_ROUND: begin
        cmd.round = 1'b1;
        if (sub == 2'd2) begin
          sub_next     = '0;
          quarter_next = quarter + 3'd1;
          if (quarter == 3'd7) begin
            if (dround == DR_W'(DOUBLE_ROUNDS - 1)) begin
              state_next = tbarx_pkg::ST_FEED;
            end
            dround_next = dround + DR_W'(1);
          end
        end else begin
          sub_next = sub + 2'd1;
        end
      end
      tbarx_pkg::ST_FEED: begin
        cmd.feed   = 1'b1;
        state_next = tbarx_pkg::ST_EMIT;
      end
      tbarx_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = tbarx_pkg::ST_IDLE;
        end
      end
      default: state_next = tbarx_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/tbarx_datapath.sv =====
// Datapath: configuration registers, block counter, two cipher states with quarter units,
// chunk position and the output register. Depends on tbarx_pkg.
module tbarx_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tbarx_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tbarx_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [tbarx_pkg::CHUNK_W-1:0]       msg_in,
  input  logic [tbarx_pkg::COUNT_W-1:0]       count_in,
  input  logic                                last_in,
  output logic [tbarx_pkg::CHUNK_W-1:0]       out_data,
  output logic                                out_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  input  tbarx_pkg::cmd_t                     cmd,
  output tbarx_pkg::status_t                  sts
);

  logic [63:0] key01, key23, key45, key67, nonce, counter;
  logic        long_mode;
  logic [tbarx_pkg::POS_W-1:0]   pos;
  logic [tbarx_pkg::CHUNK_W-1:0] msg_hold;
  logic [tbarx_pkg::COUNT_W-1:0] count_hold;
  logic                          last_hold;
  tbarx_pkg::words_t words [2];
  tbarx_pkg::words_t words_next [2];
  tbarx_pkg::words_t init0, init1;
  logic [63:0] ks, mask, hi_a, hi_b;
  logic [3:0]  count_sat;

  // Initial state of the span; the second block differs in the low counter word.
  always_comb begin
    hi_a = long_mode ? key45 : key01;
    hi_b = long_mode ? key67 : key23;
    init0[0]  = key01[31:0];    init0[1]  = key01[63:32];
    init0[2]  = key23[31:0];    init0[3]  = key23[63:32];
    init0[4]  = counter[31:0];  init0[5]  = counter[63:32];
    init0[6]  = long_mode ? tbarx_pkg::LONG_CONSTS[0] : tbarx_pkg::SHORT_CONSTS[0];
    init0[7]  = long_mode ? tbarx_pkg::LONG_CONSTS[1] : tbarx_pkg::SHORT_CONSTS[1];
    init0[8]  = hi_a[31:0];     init0[9]  = hi_a[63:32];
    init0[10] = hi_b[31:0];     init0[11] = hi_b[63:32];
    init0[12] = nonce[31:0];    init0[13] = nonce[63:32];
    init0[14] = long_mode ? tbarx_pkg::LONG_CONSTS[2] : tbarx_pkg::SHORT_CONSTS[2];
    init0[15] = long_mode ? tbarx_pkg::LONG_CONSTS[3] : tbarx_pkg::SHORT_CONSTS[3];
    init1     = init0;
    init1[4]  = init0[4] + 32'd1;
  end

  // One third of a quarter function on each block, with row rotation after the last third.
  always_comb begin
    tbarx_pkg::words_t t;
    logic [31:0] a, b, c, d, e;
    logic [1:0]  k;
    k = '0;
    for (int blk = 0; blk < 2; blk++) begin
      t = words[blk];
      a = t[0]; b = t[4]; c = t[8]; d = t[12]; e = t[3];
      unique case (cmd.sub)
        2'd0: begin
          d = d + e; c = c ^ d; b = tbarx_pkg::rotl32(b + c, 10);
        end
        2'd1: begin
          a = a + b; e = e ^ a; d = tbarx_pkg::rotl32(d + e, 27);
        end
        2'd2: begin
          c = c + d; b = b ^ c; a = tbarx_pkg::rotl32(a + b, 8);
        end
        default: begin
        end
      endcase
      t[0] = a; t[4] = b; t[8] = c; t[12] = d; t[3] = e;
      words_next[blk] = t;
      if (cmd.sub == 2'd2) begin
        for (int r = 0; r < 4; r++) begin
          k = tbarx_pkg::rot_amount(cmd.rot, r);
          for (int j = 0; j < 4; j++) begin
            words_next[blk][r*4 + j] = t[r*4 + 32'(2'(j + 32'(k)))];
          end
        end
      end
    end
  end

  // Keystream chunk for the current position and byte mask.
  always_comb begin
    ks = {words[pos[3]][{pos[2:0], 1'b1}], words[pos[3]][{pos[2:0], 1'b0}]};
    count_sat = (count_hold > 4'd8) ? 4'd8 : count_hold;
    for (int i = 0; i < 8; i++) begin
      mask[i*8 +: 8] = (4'(i) < count_sat) ? 8'hff : 8'h00;
    end
  end

  // Configuration registers and block counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      key01 <= '0; key23 <= '0; key45 <= '0; key67 <= '0;
      long_mode <= 1'b1;
      nonce   <= '0;
      counter <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tbarx_pkg::REG_KEY01: key01 <= cfg_data;
        tbarx_pkg::REG_KEY23: key23 <= cfg_data;
        tbarx_pkg::REG_KEY45: key45 <= cfg_data;
        tbarx_pkg::REG_KEY67: key67 <= cfg_data;
        tbarx_pkg::REG_LONG:  long_mode <= cfg_data[0];
        tbarx_pkg::REG_NONCE: begin
          nonce   <= cfg_data;
          counter <= '0;
        end
        default: begin
        end
      endcase
    end else if (cmd.feed) begin
      counter <= counter + 64'd2;
    end
  end

  // Cipher states: load, rounds and feed-forward.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      words[0] <= init0;
      words[1] <= init1;
    end else if (cmd.round) begin
      words[0] <= words_next[0];
      words[1] <= words_next[1];
    end else if (cmd.feed) begin
      for (int i = 0; i < 16; i++) begin
        words[0][i] <= words[0][i] + init0[i];
        words[1][i] <= words[1][i] + init1[i];
      end
    end
  end

  // Input hold registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      msg_hold   <= msg_in;
      count_hold <= count_in;
      last_hold  <= last_in;
    end
  end

  // Chunk position and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
        pos       <= last_hold ? '0 : pos + 4'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= (msg_hold ^ ks) & mask;
      out_last <= last_hold;
    end
  end

  assign sts.pos_zero = (pos == '0);
  assign sts.out_free = !out_valid || out_ready;

endmodule

// ===== rtl/two_block_arx_stream_cipher_core.sv =====
// Two-block ARX stream cipher, 8-byte chunks in and out.
// Mid-span an accepted beat is held and its result loaded into the output register once free;
// at a span start the two blocks are loaded, run through the rounds (two quarter units, a
// third of a quarter at a time) and fed forward. One item at a time; spans of up to 16 chunks.
// Reset (rst, synchronous): counter, chunk position and keys clear, long-key mode set.
// Depends on tbarx_pkg, tbarx_if, tbarx_ctrl and tbarx_datapath.
module two_block_arx_stream_cipher_core #(
  parameter int DOUBLE_ROUNDS = tbarx_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tbarx_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tbarx_pkg::CFG_DATA_W-1:0]  cfg_data,
  tbarx_in_if.sink                          in_ch,
  tbarx_out_if.source                       out_ch
);

  tbarx_pkg::cmd_t    cmd;
  tbarx_pkg::status_t sts;

  tbarx_ctrl #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tbarx_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .msg_in    (in_ch.message_chunk),
    .count_in  (in_ch.byte_count),
    .last_in   (in_ch.end_of_message),
    .out_data  (out_ch.cipher_chunk),
    .out_last  (out_ch.chunk_is_last),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // One item at a time: no second beat right after an accepted one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted while an item is in progress");

  // A result is loaded only into a free output slot.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result overwrote a pending beat");

  // Every loaded result shows up on the output.
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_ch.valid)
    else $error("loaded result not presented");

endmodule

// ===== sim/two_block_arx_stream_cipher_core_tb.sv =====
// Self-checking testbench for the two-block ARX stream cipher core.
// Drives chunk beats, predicts the keystream XOR, and checks each result beat in order.
// Depends on tbarx_pkg, tbarx_if and the two_block_arx_stream_cipher_core RTL.
module two_block_arx_stream_cipher_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [63:0] chunk;
    logic [3:0]  count;
    logic        last;
  } chunk_beat_t;

  typedef struct {
    logic [63:0] cipher;
    logic        last;
  } cipher_beat_t;

  localparam int CYCLE_LIMIT = 1500000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [tbarx_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [tbarx_pkg::CFG_DATA_W-1:0] cfg_data;

  tbarx_in_if in_ch ();
  tbarx_out_if out_ch ();

  two_block_arx_stream_cipher_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  // Predictor copy of the registers and span state.
  logic [63:0] key01, key23, key45, key67, nonce, blk_ctr;
  logic        long_mode;
  logic [63:0] keystream [16];
  int unsigned span_pos;

  chunk_beat_t  pending_chunks [$];
  cipher_beat_t expected_cipher [$];
  int unsigned errors = 0;
  int unsigned send_idle_pct, recv_idle_pct;
  longint unsigned cycles = 0;
  logic in_fire;
  event hold_start;
  logic hold_active = 1'b0;

  function automatic logic [31:0] rot_left(logic [31:0] v, int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  task automatic arx_quarter(inout logic [31:0] w [16], input int a, b, c, d, e);
    w[d] += w[e]; w[c] ^= w[d]; w[b] += w[c]; w[b] = rot_left(w[b], 10);
    w[a] += w[b]; w[e] ^= w[a]; w[d] += w[e]; w[d] = rot_left(w[d], 27);
    w[c] += w[d]; w[b] ^= w[c]; w[a] += w[b]; w[a] = rot_left(w[a], 8);
  endtask

  // Run the double rounds on one state and add the input state back.
  task automatic arx_block(input logic [31:0] init [16], output logic [31:0] w [16]);
    w = init;
    for (int r = 0; r < tbarx_pkg::DOUBLE_ROUNDS_DEF; r++) begin
      arx_quarter(w, 0, 4, 8, 12, 3);
      arx_quarter(w, 1, 5, 9, 13, 0);
      arx_quarter(w, 2, 6, 10, 14, 1);
      arx_quarter(w, 3, 7, 11, 15, 2);
      arx_quarter(w, 0, 5, 10, 15, 3);
      arx_quarter(w, 1, 6, 11, 12, 0);
      arx_quarter(w, 2, 7, 8, 13, 1);
      arx_quarter(w, 3, 4, 9, 14, 2);
    end
    for (int i = 0; i < 16; i++) w[i] += init[i];
  endtask

  // Build 128 keystream bytes for a new span and step the block counter.
  task automatic build_keystream();
    logic [31:0] init [16];
    logic [31:0] wa [16];
    logic [31:0] wb [16];
    logic [63:0] hi_a, hi_b;
    hi_a = long_mode ? key45 : key01;
    hi_b = long_mode ? key67 : key23;
    init[0] = key01[31:0];   init[1] = key01[63:32];
    init[2] = key23[31:0];   init[3] = key23[63:32];
    init[4] = blk_ctr[31:0]; init[5] = blk_ctr[63:32];
    init[6] = long_mode ? tbarx_pkg::LONG_CONSTS[0] : tbarx_pkg::SHORT_CONSTS[0];
    init[7] = long_mode ? tbarx_pkg::LONG_CONSTS[1] : tbarx_pkg::SHORT_CONSTS[1];
    init[8] = hi_a[31:0];    init[9] = hi_a[63:32];
    init[10] = hi_b[31:0];   init[11] = hi_b[63:32];
    init[12] = nonce[31:0];  init[13] = nonce[63:32];
    init[14] = long_mode ? tbarx_pkg::LONG_CONSTS[2] : tbarx_pkg::SHORT_CONSTS[2];
    init[15] = long_mode ? tbarx_pkg::LONG_CONSTS[3] : tbarx_pkg::SHORT_CONSTS[3];
    arx_block(init, wa);
    init[4] += 32'd1;
    arx_block(init, wb);
    for (int i = 0; i < 8; i++) begin
      keystream[i] = {wa[2*i+1], wa[2*i]};
      keystream[8+i] = {wb[2*i+1], wb[2*i]};
    end
    blk_ctr += 64'd2;
  endtask

  task automatic predict_cipher(input chunk_beat_t b);
    cipher_beat_t r;
    int unsigned n;
    logic [63:0] mask;
    n = (b.count > 8) ? 8 : b.count;
    mask = (n == 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
    if (span_pos == 0) build_keystream();
    r.cipher = (b.chunk ^ keystream[span_pos]) & mask;
    r.last = b.last;
    expected_cipher.push_back(r);
    span_pos = b.last ? 0 : (span_pos + 1) % 16;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // Register write at the falling edge; the predictor picks it up at the next rising edge.
  task automatic write_reg(input tbarx_pkg::reg_index_t idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_chunk(input logic [63:0] c, input logic [3:0] n, input logic l);
    chunk_beat_t b;
    b.chunk = c; b.count = n; b.last = l;
    pending_chunks.push_back(b);
  endtask

  task automatic wait_drained();
    while (pending_chunks.size() != 0 || expected_cipher.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic random_message();
    int unsigned len;
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 18);
    for (int i = 0; i < len; i++) begin
      if (i == len - 1) queue_chunk({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b1);
      else if ($urandom_range(0, 9) == 0)
        queue_chunk({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b0);
      else queue_chunk({$urandom, $urandom}, 4'd8, 1'b0);
    end
  endtask

  task automatic random_keys();
    write_reg(tbarx_pkg::REG_KEY01, {$urandom, $urandom});
    write_reg(tbarx_pkg::REG_KEY23, {$urandom, $urandom});
    write_reg(tbarx_pkg::REG_KEY45, {$urandom, $urandom});
    write_reg(tbarx_pkg::REG_KEY67, {$urandom, $urandom});
    write_reg(tbarx_pkg::REG_LONG, 64'($urandom_range(0, 1)));
    write_reg(tbarx_pkg::REG_NONCE, {$urandom, $urandom});
  endtask

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Driver: offers the head of the pending queue, idling at random.
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.message_chunk <= '0;
      in_ch.byte_count <= '0;
      in_ch.end_of_message <= 1'b0;
    end else if (in_ch.valid && !in_fire) begin
      // Hold the beat until it is taken.
    end else if (pending_chunks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      in_ch.valid <= 1'b1;
      in_ch.message_chunk <= pending_chunks[0].chunk;
      in_ch.byte_count <= pending_chunks[0].count;
      in_ch.end_of_message <= pending_chunks[0].last;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Predictor: register writes and accepted input beats, in edge order.
  always @(posedge clk) begin
    if (rst) begin
      key01 = 0; key23 = 0; key45 = 0; key67 = 0; nonce = 0; blk_ctr = 0;
      long_mode = 1'b1;
      span_pos = 0;
      in_fire <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tbarx_pkg::REG_KEY01: key01 = cfg_data;
          tbarx_pkg::REG_KEY23: key23 = cfg_data;
          tbarx_pkg::REG_KEY45: key45 = cfg_data;
          tbarx_pkg::REG_KEY67: key67 = cfg_data;
          tbarx_pkg::REG_LONG:  long_mode = cfg_data[0];
          tbarx_pkg::REG_NONCE: begin
            nonce = cfg_data;
            blk_ctr = 0;
          end
          default: ;
        endcase
      end
      in_fire <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        predict_cipher(pending_chunks.pop_front());
      end
    end
  end

  // Long receiver hold-off, counted in cycles.
  always begin
    @(hold_start);
    hold_active = 1'b1;
    repeat (400) @(negedge clk);
    hold_active = 1'b0;
  end

  // Receiver ready, with random stalls and an optional long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_active) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    cipher_beat_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_cipher.size() == 0) begin
        report_mismatch("unexpected beat", out_ch.cipher_chunk, 64'd0);
      end else begin
        want = expected_cipher.pop_front();
        if (out_ch.cipher_chunk !== want.cipher)
          report_mismatch("cipher_chunk", out_ch.cipher_chunk, want.cipher);
        if (out_ch.chunk_is_last !== want.last)
          report_mismatch("chunk_is_last", 64'(out_ch.chunk_is_last), 64'(want.last));
      end
    end
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Main sequence: reset, directed chunks, extreme registers, a long hold-off, then random phases.
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    send_idle_pct = 36; recv_idle_pct = 70;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset keys, extremes, short chunks, counts zero and above eight.
    queue_chunk(64'd0, 4'd8, 1'b0);
    queue_chunk('1, 4'd8, 1'b0);
    queue_chunk({$urandom, $urandom}, 4'd3, 1'b0);
    queue_chunk({$urandom, $urandom}, 4'd0, 1'b0);
    queue_chunk({$urandom, $urandom}, 4'd15, 1'b0);
    queue_chunk({$urandom, $urandom}, 4'd1, 1'b1);
    for (int i = 0; i < 18; i++) queue_chunk({$urandom, $urandom}, 4'd8, i == 17);
    wait_drained();

    // Extreme registers in short-key mode.
    write_reg(tbarx_pkg::REG_KEY01, '1);
    write_reg(tbarx_pkg::REG_KEY23, '1);
    write_reg(tbarx_pkg::REG_KEY45, '1);
    write_reg(tbarx_pkg::REG_KEY67, '1);
    write_reg(tbarx_pkg::REG_LONG, 64'd0);
    write_reg(tbarx_pkg::REG_NONCE, '1);
    for (int i = 0; i < 3; i++) random_message();
    wait_drained();

    // Long hold-off so the core fills and stalls its input.
    random_keys();
    -> hold_start;
    for (int i = 0; i < 40; i++) queue_chunk({$urandom, $urandom}, 4'd8, i == 39);
    wait_drained();

    // Random phases with three idling profiles.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 70 : 0;
      recv_idle_pct = (ph == 0) ? 70 : (ph == 1) ? 36 : 0;
      for (int s = 0; s < 3; s++) begin
        random_keys();
        for (int m = 0; m < 7; m++) random_message();
        wait_drained();
      end
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
